@@ hw/rtl/multichannel_lut_color_merge_macros.svh @@
// Assertion macros for the multichannel LUT color merge checker.
// No dependencies; every macro samples on clk and is disabled while rst_n is low.
`ifndef MULTICHANNEL_LUT_COLOR_MERGE_MACROS_SVH
`define MULTICHANNEL_LUT_COLOR_MERGE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MCLM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MCLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mclm_pkg.sv @@
// Shared constants, codes, stage payload types and helpers for the color merge.
// No dependencies; every other RTL file but the macros header imports it.
package mclm_pkg;

  localparam int CHANNELS      = 4;
  localparam int TABLE_ENTRIES = 256;
  localparam int SAMPLE_LANES  = 4;
  localparam int LANES         = (CHANNELS < SAMPLE_LANES) ? CHANNELS : SAMPLE_LANES;

  localparam int SAMPLE_W  = 8;
  localparam int SAMPLES_W = SAMPLE_LANES * SAMPLE_W;
  localparam int WEIGHT_W  = 17;
  localparam int IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int CHAN_W    = 2;
  localparam int COLOR_W   = 8;
  localparam int SUM_W     = WEIGHT_W + $clog2(LANES);
  localparam int AVG_W     = SAMPLE_W + $clog2(LANES);
  localparam int CNT_W     = $clog2(LANES + 1);
  localparam int NUSED_W   = 3;

  localparam int SCALE_SHIFT  = 16;
  localparam int RECIP3       = 683;   // 2^11 / 3, exact for dividends below 2048
  localparam int RECIP3_SHIFT = 11;
  localparam int LUMA_W       = 16;
  localparam int LUMA_R       = 77;
  localparam int LUMA_G       = 151;
  localparam int LUMA_B       = 28;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [NUSED_W-1:0]  RST_CHANNELS    = 3'd4;
  localparam logic                RST_BUILD_ALPHA = 1'b0;
  localparam logic [1:0]          RST_ALPHA_MODE  = 2'd0;
  localparam logic [SAMPLE_W-1:0] RST_THRESHOLD   = 8'd10;

  typedef enum logic {
    CMD_MERGE = 1'b0,
    CMD_LOAD  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ALPHA_MEAN = 2'd0,
    ALPHA_MAX  = 2'd1,
    ALPHA_LUMA = 2'd2
  } alpha_mode_t;

  typedef enum logic [1:0] {
    REG_CHANNELS    = 2'd0,
    REG_BUILD_ALPHA = 2'd1,
    REG_ALPHA_MODE  = 2'd2,
    REG_THRESHOLD   = 2'd3
  } reg_idx_t;

  typedef logic [WEIGHT_W-1:0] weight_t;

  // bit layout matches the table word: red low, blue high
  typedef struct packed {
    weight_t blue;
    weight_t green;
    weight_t red;
  } entry_t;

  typedef struct packed {
    logic [NUSED_W-1:0]  channels;
    logic                build_alpha;
    logic [1:0]          alpha_mode;
    logic [SAMPLE_W-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0]    sum_r;
    logic [SUM_W-1:0]    sum_g;
    logic [SUM_W-1:0]    sum_b;
    logic [SAMPLE_W-1:0] max_s;
    logic [AVG_W-1:0]    avg_sum;
    logic [CNT_W-1:0]    avg_cnt;
  } s2_t;

  typedef struct packed {
    logic [COLOR_W-1:0]  r;
    logic [COLOR_W-1:0]  g;
    logic [COLOR_W-1:0]  b;
    logic [SAMPLE_W-1:0] max_s;
    logic [SAMPLE_W-1:0] mean;
  } s3_t;

  // channel count saturated to the lanes that exist
  function automatic logic [NUSED_W-1:0] lanes_used(input logic [NUSED_W-1:0] ch);
    if (int'(ch) > LANES) begin
      return NUSED_W'(LANES);
    end
    return ch;
  endfunction

endpackage

@@ hw/rtl/mclm_if.sv @@
// Valid/ready channel interfaces for the pixel/load input and the RGBA output.
// Depends on mclm_pkg.
interface mclm_in_if;
  import mclm_pkg::*;
  logic                 valid;
  logic                 ready;
  cmd_t                 command;
  logic [SAMPLES_W-1:0] samples;
  logic [CHAN_W-1:0]    table_channel;
  logic [IDX_W-1:0]     table_index;
  weight_t              table_red;
  weight_t              table_green;
  weight_t              table_blue;

  modport source (output valid, command, samples, table_channel, table_index,
                  table_red, table_green, table_blue, input ready);
  modport sink   (input valid, command, samples, table_channel, table_index,
                  table_red, table_green, table_blue, output ready);
endinterface

interface mclm_out_if;
  import mclm_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [COLOR_W-1:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

@@ hw/rtl/multichannel_lut_color_merge.sv @@
// Top level of the multichannel LUT color merge: four-stage pixel pipeline.
// Depends on mclm_pkg, mclm_if, mclm_cfg, mclm_lut, mclm_accum, mclm_scale, mclm_alpha.
//
//  channel   dir  handshake            beat
//  in_chan   in   valid/ready          merge pixel or one table load
//  out_chan  out  valid/ready          one RGBA pixel per merge beat
//  psel..    in   APB, pready tied 1   register write/read
//
// One beat per clock while out_chan is not stalled. A merge beat passes four
// register stages (table read, sum, scale/mean, luma/alpha) on its way to out_chan;
// a load beat writes its table entry at the accept edge and gives no result. Each
// stage has its own valid bit, so bubbles are squeezed out while out_chan is
// stalled. Reset clears the valid bits and the config registers; the tables hold
// nothing defined until loaded.
module multichannel_lut_color_merge import mclm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mclm_in_if.sink               in_chan,
  mclm_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t                 cfg;
  entry_t [LANES-1:0]   entries;
  logic [SAMPLES_W-1:0] samples1;
  s2_t                  s2;
  s3_t                  s3;
  logic                 v1_r, v2_r, v3_r, v4_r;
  logic                 rdy1, rdy2, rdy3, rdy4;
  logic                 acc;
  entry_t               wr_entry;

  assign rdy4 = !v4_r || out_chan.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_chan.ready = rdy1;
  assign acc           = in_chan.valid && rdy1;

  assign wr_entry.red   = in_chan.table_red;
  assign wr_entry.green = in_chan.table_green;
  assign wr_entry.blue  = in_chan.table_blue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= acc && (in_chan.command == CMD_MERGE);
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  mclm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mclm_lut u_lut (
    .clk        (clk),
    .we         (acc && (in_chan.command == CMD_LOAD)),
    .wr_channel (in_chan.table_channel),
    .wr_index   (in_chan.table_index),
    .wr_entry   (wr_entry),
    .en         (rdy1),
    .samples    (in_chan.samples),
    .rd_entry   (entries),
    .samples_r  (samples1)
  );

  mclm_accum u_accum (
    .clk     (clk),
    .en      (rdy2),
    .cfg     (cfg),
    .entries (entries),
    .samples (samples1),
    .s2_r    (s2)
  );

  mclm_scale u_scale (
    .clk  (clk),
    .en   (rdy3),
    .s2   (s2),
    .s3_r (s3)
  );

  mclm_alpha u_alpha (
    .clk     (clk),
    .en      (rdy4),
    .cfg     (cfg),
    .s3      (s3),
    .red_r   (out_chan.red),
    .green_r (out_chan.green),
    .blue_r  (out_chan.blue),
    .alpha_r (out_chan.alpha)
  );

  assign out_chan.valid = v4_r;

endmodule

@@ hw/rtl/mclm_cfg.sv @@
// APB-style configuration registers of the color merge.
// Depends on mclm_pkg.
module mclm_cfg import mclm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channels    <= RST_CHANNELS;
      cfg_r.build_alpha <= RST_BUILD_ALPHA;
      cfg_r.alpha_mode  <= RST_ALPHA_MODE;
      cfg_r.threshold   <= RST_THRESHOLD;
    end else if (wr) begin
      unique case (idx)
        REG_CHANNELS:    cfg_r.channels    <= pwdata[NUSED_W-1:0];
        REG_BUILD_ALPHA: cfg_r.build_alpha <= pwdata[0];
        REG_ALPHA_MODE:  cfg_r.alpha_mode  <= pwdata[1:0];
        REG_THRESHOLD:   cfg_r.threshold   <= pwdata[SAMPLE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CHANNELS:    prdata = APB_DATA_W'(cfg_r.channels);
      REG_BUILD_ALPHA: prdata = APB_DATA_W'(cfg_r.build_alpha);
      REG_ALPHA_MODE:  prdata = APB_DATA_W'(cfg_r.alpha_mode);
      REG_THRESHOLD:   prdata = APB_DATA_W'(cfg_r.threshold);
    endcase
  end

endmodule

@@ hw/rtl/mclm_lut.sv @@
// Stage 1: per-lane color table memories, one write port and one registered read each.
// Depends on mclm_pkg.
module mclm_lut import mclm_pkg::*; (
  input  logic                 clk,
  input  logic                 we,
  input  logic [CHAN_W-1:0]    wr_channel,
  input  logic [IDX_W-1:0]     wr_index,
  input  entry_t               wr_entry,
  input  logic                 en,
  input  logic [SAMPLES_W-1:0] samples,
  output entry_t [LANES-1:0]   rd_entry,
  output logic [SAMPLES_W-1:0] samples_r
);

  for (genvar c = 0; c < LANES; c++) begin : g_lane
    entry_t mem [TABLE_ENTRIES];
    entry_t rd_r;

    // loads to a channel with no lane are dropped
    always_ff @(posedge clk) begin
      if (we && (int'(wr_channel) == c)) begin
        mem[wr_index] <= wr_entry;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rd_r <= mem[samples[c*SAMPLE_W +: IDX_W]];
      end
    end

    assign rd_entry[c] = rd_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      samples_r <= samples;
    end
  end

endmodule

@@ hw/rtl/mclm_accum.sv @@
// Stage 2: per-color sums of the looked-up weights, max sample, above-threshold stats.
// Depends on mclm_pkg.
module mclm_accum import mclm_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  cfg_t                 cfg,
  input  entry_t [LANES-1:0]   entries,
  input  logic [SAMPLES_W-1:0] samples,
  output s2_t                  s2_r
);

  s2_t                s2_nxt;
  logic [NUSED_W-1:0] n_used;

  assign n_used = lanes_used(cfg.channels);

  always_comb begin
    logic [SAMPLE_W-1:0] s;
    s2_nxt = '0;
    for (int c = 0; c < LANES; c++) begin
      s = samples[c*SAMPLE_W +: SAMPLE_W];
      if (c < int'(n_used)) begin
        s2_nxt.sum_r = s2_nxt.sum_r + SUM_W'(entries[c].red);
        s2_nxt.sum_g = s2_nxt.sum_g + SUM_W'(entries[c].green);
        s2_nxt.sum_b = s2_nxt.sum_b + SUM_W'(entries[c].blue);
        if (s > s2_nxt.max_s) begin
          s2_nxt.max_s = s;
        end
        if (s > cfg.threshold) begin
          s2_nxt.avg_sum = s2_nxt.avg_sum + AVG_W'(s);
          s2_nxt.avg_cnt = s2_nxt.avg_cnt + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

@@ hw/rtl/mclm_scale.sv @@
// Stage 3: scale sums by 255/65536 with clamp, and the mean of qualifying samples.
// Depends on mclm_pkg.
module mclm_scale import mclm_pkg::*; (
  input  logic clk,
  input  logic en,
  input  s2_t  s2,
  output s3_t  s3_r
);

  localparam int PROD_W = SUM_W + COLOR_W;
  localparam int Q3_W   = AVG_W + 10;

  s3_t             s3_nxt;
  logic [Q3_W-1:0] q3;

  // x*255 as (x<<8)-x, then >>16 and saturate to 8 bits
  function automatic logic [COLOR_W-1:0] scale_clamp(input logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] p;
    p = {sum, {COLOR_W{1'b0}}} - PROD_W'(sum);
    if (p[PROD_W-1:SCALE_SHIFT+COLOR_W] != '0) begin
      return {COLOR_W{1'b1}};
    end
    return p[SCALE_SHIFT+COLOR_W-1:SCALE_SHIFT];
  endfunction

  assign q3 = Q3_W'(s2.avg_sum) * Q3_W'(RECIP3);

  always_comb begin
    s3_nxt.r     = scale_clamp(s2.sum_r);
    s3_nxt.g     = scale_clamp(s2.sum_g);
    s3_nxt.b     = scale_clamp(s2.sum_b);
    s3_nxt.max_s = s2.max_s;
    // count is at most four, so each divisor gets its own path
    priority if (int'(s2.avg_cnt) == 1) begin
      s3_nxt.mean = SAMPLE_W'(s2.avg_sum);
    end else if (int'(s2.avg_cnt) == 2) begin
      s3_nxt.mean = SAMPLE_W'(s2.avg_sum >> 1);
    end else if (int'(s2.avg_cnt) == 3) begin
      s3_nxt.mean = SAMPLE_W'(q3 >> RECIP3_SHIFT);
    end else if (int'(s2.avg_cnt) == 4) begin
      s3_nxt.mean = SAMPLE_W'(s2.avg_sum >> 2);
    end else begin
      s3_nxt.mean = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

@@ hw/rtl/mclm_alpha.sv @@
// Stage 4: luminance, alpha selection and the output pixel register.
// Depends on mclm_pkg.
module mclm_alpha import mclm_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  cfg_t               cfg,
  input  s3_t                s3,
  output logic [COLOR_W-1:0] red_r,
  output logic [COLOR_W-1:0] green_r,
  output logic [COLOR_W-1:0] blue_r,
  output logic [COLOR_W-1:0] alpha_r
);

  logic [LUMA_W-1:0]  luma;
  logic [COLOR_W-1:0] alpha_nxt;

  assign luma = LUMA_W'(LUMA_R) * LUMA_W'(s3.r)
              + LUMA_W'(LUMA_G) * LUMA_W'(s3.g)
              + LUMA_W'(LUMA_B) * LUMA_W'(s3.b);

  always_comb begin
    alpha_nxt = '0;
    if (cfg.build_alpha && (lanes_used(cfg.channels) != '0)) begin
      unique case (cfg.alpha_mode)
        ALPHA_MEAN: alpha_nxt = s3.mean;
        ALPHA_MAX:  alpha_nxt = s3.max_s;
        default:    alpha_nxt = luma[LUMA_W-1:LUMA_W-COLOR_W];  // mode 3 acts as luma
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= s3.r;
      green_r <= s3.g;
      blue_r  <= s3.b;
      alpha_r <= alpha_nxt;
    end
  end

endmodule

@@ hw/rtl/mclm_checker.sv @@
// Port-level checker for the color merge, bound to the top level.
// Depends on mclm_pkg and multichannel_lut_color_merge_macros.svh.
`include "multichannel_lut_color_merge_macros.svh"

module mclm_checker import mclm_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [4*COLOR_W-1:0]  out_pixel,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [APB_DATA_W-1:0] pwdata,
  input logic [APB_DATA_W-1:0] prdata
);

  logic wr;
  assign wr = psel && penable && pwrite;

  // a stalled result beat stays put
  `MCLM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel), "stalled output beat changed")

  // with nothing waiting at the output every stage can move
  `MCLM_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready, "input stalled with empty output")

  // register writes are captured at the field width
  `MCLM_ASSERT_NEXT(a_rd_channels, wr && (paddr[3:2] == REG_CHANNELS), (paddr[3:2] != REG_CHANNELS) || (prdata == APB_DATA_W'($past(pwdata[NUSED_W-1:0]))), "channel count readback mismatch")

  `MCLM_ASSERT_NEXT(a_rd_threshold, wr && (paddr[3:2] == REG_THRESHOLD), (paddr[3:2] != REG_THRESHOLD) || (prdata == APB_DATA_W'($past(pwdata[SAMPLE_W-1:0]))), "threshold readback mismatch")

endmodule

bind multichannel_lut_color_merge mclm_checker u_mclm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_pixel ({out_chan.alpha, out_chan.blue, out_chan.green, out_chan.red}),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
